[hw/rtl/frinv_pkg.sv]
// Package for the framebuffer rectangle invert block: payload structs, op and
// command codes, and size constants. No dependencies.
`default_nettype none

package frinv_pkg;

	localparam int DEF_STRIDE_BYTES = 20;
	localparam int DEF_FRAME_ROWS   = 144;

	// Widest store address over the parameter range (32 x 256 bytes).
	localparam int ADDR_W = 13;
	// Byte column within a row (up to 32 bytes).
	localparam int COL_W  = 5;
	// Width that holds the store size itself.
	localparam int SIZE_W = ADDR_W + 1;

	localparam int CMDQ_DEPTH = 2;

	localparam logic [1:0] OP_INVERT = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] K_NOP    = 2'd0;
	localparam logic [1:0] K_WRITE  = 2'd1;
	localparam logic [1:0] K_READ   = 2'd2;
	localparam logic [1:0] K_INVERT = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  rect_x;
		logic [7:0]  rect_y;
		logic [7:0]  rect_w;
		logic [7:0]  rect_h;
		logic [11:0] byte_addr;
		logic [7:0]  byte_data;
	} in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       status;
		logic [7:0] dirty_first_row;
		logic [7:0] dirty_rows;
	} res_t;

	// Classified command passed from front to back.
	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;       // byte address, or row base for an invert
		logic [7:0]        data;
		logic [COL_W-1:0]  first_col;
		logic [COL_W-1:0]  last_col;
		logic [7:0]        lead_mask;  // already merged when span fits one byte
		logic [7:0]        tail_mask;
		logic [7:0]        rows;
		res_t              res;
	} cmd_t;

endpackage

`default_nettype wire

[hw/rtl/frinv_front.sv]
// Front classifier: checks bounds, builds edge masks and row base per request.
// Depends on frinv_pkg.
`default_nettype none

module frinv_front import frinv_pkg::*; #(
	parameter int STRIDE_BYTES = DEF_STRIDE_BYTES,
	parameter int FRAME_ROWS   = DEF_FRAME_ROWS
) (
	input  wire in_t  item,
	output cmd_t      cmd
);

	localparam int DEPTH = STRIDE_BYTES * FRAME_ROWS;

	logic [8:0]  sum_x;
	logic [8:0]  sum_y;
	logic [7:0]  end_x;
	logic        outside;
	logic        empty_rect;
	logic        addr_ok;
	logic [COL_W-1:0] first_col;
	logic [COL_W-1:0] last_col;
	logic [7:0]  fmask;
	logic [7:0]  lmask;

	always_comb begin
		sum_x      = {1'b0, item.rect_x} + {1'b0, item.rect_w};
		sum_y      = {1'b0, item.rect_y} + {1'b0, item.rect_h};
		end_x      = 8'(sum_x - 9'd1);
		outside    = (sum_x > 9'(STRIDE_BYTES * 8)) || (sum_y > 9'(FRAME_ROWS));
		empty_rect = (item.rect_w == 8'd0) || (item.rect_h == 8'd0);
		addr_ok    = {2'b00, item.byte_addr} < SIZE_W'(DEPTH);
		first_col  = COL_W'(item.rect_x[7:3]);
		last_col   = COL_W'(end_x[7:3]);
		fmask      = 8'hFF >> item.rect_x[2:0];
		lmask      = 8'hFF << (3'd7 - end_x[2:0]);

		cmd            = '0;
		cmd.data       = item.byte_data;
		cmd.first_col  = first_col;
		cmd.last_col   = last_col;
		cmd.lead_mask  = (first_col == last_col) ? (fmask & lmask) : fmask;
		cmd.tail_mask  = lmask;
		cmd.rows       = item.rect_h;

		case (item.op)
			OP_INVERT: begin
				if (!empty_rect) begin
					if (outside) begin
						cmd.res.status = 1'b1;
					end else begin
						cmd.kind                = K_INVERT;
						cmd.addr                = ADDR_W'({5'b0, item.rect_y}
						                          * ADDR_W'(STRIDE_BYTES));
						cmd.res.dirty_first_row = item.rect_y;
						cmd.res.dirty_rows      = item.rect_h;
					end
				end
			end
			OP_WRITE: begin
				if (addr_ok) begin
					cmd.kind = K_WRITE;
					cmd.addr = ADDR_W'(item.byte_addr);
				end
			end
			OP_READ: begin
				if (addr_ok) begin
					cmd.kind = K_READ;
					cmd.addr = ADDR_W'(item.byte_addr);
				end
			end
			default: begin
				cmd.kind = K_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/frinv_cmdq.sv]
// Short command queue between the front classifier and the back sequencer.
// Depends on frinv_pkg.
`default_nettype none

module frinv_cmdq import frinv_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       wr,
	input  wire cmd_t wr_cmd,
	output logic      full,
	input  wire       rd,
	output cmd_t      head,
	output logic      empty
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(CMDQ_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/frinv_back.sv]
// Back sequencer: owns the frame store, executes byte accesses and walks
// invert rectangles with a read-modify-write pipeline. Depends on frinv_pkg.
`default_nettype none

module frinv_back import frinv_pkg::*; #(
	parameter int STRIDE_BYTES = DEF_STRIDE_BYTES,
	parameter int FRAME_ROWS   = DEF_FRAME_ROWS
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       q_empty,
	input  wire cmd_t q_head,
	output logic      q_pop,
	output logic      empty,
	input  wire       pop,
	output res_t      result
);

	localparam int DEPTH = STRIDE_BYTES * FRAME_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_READ  = 2'd3;

	logic [7:0]        mem [DEPTH];

	logic [1:0]        state_q;
	cmd_t              cur_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [7:0]        rows_q;
	logic              wr_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic [7:0]        mask_s1;
	logic [7:0]        rdata_s1;
	logic              out_valid_q;
	res_t              out_q;

	logic              start;
	logic              walk;
	logic              row_end;
	logic [ADDR_W-1:0] walk_addr;
	logic [7:0]        walk_mask;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_ra;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;
	logic              finish;
	res_t              fin_res;

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_comb begin
		start     = (state_q == S_IDLE) && !q_empty && (!out_valid_q || pop);
		q_pop     = start;
		walk      = (state_q == S_WALK);
		row_end   = (col_q == cur_q.last_col);
		walk_addr = row_base_q + ADDR_W'(col_q);
		if (col_q == cur_q.first_col) begin
			walk_mask = cur_q.lead_mask;
		end else if (row_end) begin
			walk_mask = cur_q.tail_mask;
		end else begin
			walk_mask = 8'hFF;
		end

		mem_re = walk || (start && (q_head.kind == K_READ));
		mem_ra = walk ? walk_addr : q_head.addr;
		mem_we = wr_s1 || (start && (q_head.kind == K_WRITE));
		mem_wa = wr_s1 ? waddr_s1 : q_head.addr;
		mem_wd = wr_s1 ? (rdata_s1 ^ mask_s1) : q_head.data;

		finish  = 1'b0;
		fin_res = cur_q.res;
		case (state_q)
			S_IDLE: begin
				fin_res = q_head.res;
				finish  = start && (q_head.kind != K_READ) && (q_head.kind != K_INVERT);
			end
			S_DRAIN: begin
				finish = 1'b1;
			end
			S_READ: begin
				finish            = 1'b1;
				fin_res.read_data = rdata_s1;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// Frame store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa[AW-1:0]] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_ra[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_s1 <= walk;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (q_head.kind == K_READ) begin
							state_q <= S_READ;
						end else if (q_head.kind == K_INVERT) begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (row_end && (rows_q == 8'd1)) begin
						state_q <= S_DRAIN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= walk_addr;
		mask_s1  <= walk_mask;
		if (finish) begin
			out_q <= fin_res;
		end
		if (start) begin
			cur_q      <= q_head;
			col_q      <= q_head.first_col;
			row_base_q <= q_head.addr;
			rows_q     <= q_head.rows;
		end else if (walk) begin
			if (row_end) begin
				col_q      <= cur_q.first_col;
				row_base_q <= row_base_q + ADDR_W'(STRIDE_BYTES);
				rows_q     <= rows_q - 8'd1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/framebuffer_rect_invert.sv]
// Top level of the monochrome framebuffer with byte access and rectangle invert.
// Depends on frinv_pkg, frinv_front, frinv_cmdq and frinv_back.
//
//   channel   handshake          payload            accepted when
//   -------   ----------------   ----------------   --------------------
//   request   push / full        item   (in_t)      push && !full
//   result    empty / pop        result (res_t)     pop && !empty
//
// Every request yields exactly one result, in request order.
// Back sequencer per request: write, bounds reject and no-op finish on acceptance;
// read passes through the registered store read (S_READ); invert walks the
// rectangle through the single store read/write port pair one byte per cycle,
// then passes through a drain state (S_DRAIN) for the last write.
// Reset clears control only; the frame store holds garbage until written.
// A full result register holds the back side; the command queue keeps taking
// requests until it fills.
`default_nettype none

module framebuffer_rect_invert import frinv_pkg::*; #(
	parameter int STRIDE_BYTES = DEF_STRIDE_BYTES,
	parameter int FRAME_ROWS   = DEF_FRAME_ROWS
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push,
	output logic      full,
	input  wire in_t  item,
	output logic      empty,
	input  wire       pop,
	output res_t      result
);

	cmd_t front_cmd;
	cmd_t q_head;
	logic q_empty;
	logic q_pop;

	// Classify the request before it enters the queue.
	frinv_front #(
		.STRIDE_BYTES(STRIDE_BYTES),
		.FRAME_ROWS  (FRAME_ROWS)
	) u_front (
		.item(item),
		.cmd (front_cmd)
	);

	// Decouple acceptance from execution.
	frinv_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wr_cmd(front_cmd),
		.full  (full),
		.rd    (q_pop),
		.head  (q_head),
		.empty (q_empty)
	);

	// Execute commands against the store and hold the result.
	frinv_back #(
		.STRIDE_BYTES(STRIDE_BYTES),
		.FRAME_ROWS  (FRAME_ROWS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire
